FILE: sv/twdcm_pkg.sv
package twdcm_pkg;

    // sequencer phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TX    = 3'd1;
    localparam logic [2:0] PH_WAIT  = 3'd2;
    localparam logic [2:0] PH_DUMMY = 3'd3;
    localparam logic [2:0] PH_RX    = 3'd4;

    // beat kind carried in s_axis_tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // data bytes the link supports after the opcode, limited by the beat layout
    localparam int unsigned MAX_DATA_BYTES = 3;
    localparam logic [1:0]  DATA_LIMIT     =
        (MAX_DATA_BYTES < 3) ? 2'(MAX_DATA_BYTES) : 2'd3;
    localparam logic [1:0]  REPLY_LIMIT    = 2'd2;

    localparam logic [7:0] READY_TRIES_RESET = 8'd16;
    localparam logic [7:0] FORCE_REPLY_MASK  = 8'h04;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 24;

    // one input beat
    typedef struct packed {
        logic       cmd;
        logic [7:0] command_byte;
        logic [1:0] data_count;
        logic [7:0] data_byte0;
        logic [7:0] data_byte1;
        logic [7:0] data_byte2;
        logic [1:0] reply_count;
        logic       force_reply_bit;
        logic       dd_in;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [15:0] response_word;
        logic        ok;
        logic        done_res;
        logic        busy_res;
        logic        dd_drive;
        logic        dd_out;
        logic        dc_level;
    } result_t;

endpackage

FILE: sv/twdcm_seq.sv
module twdcm_seq import twdcm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  item_t      item,
    input  logic [7:0] ready_tries,
    output result_t    res
);

    logic [2:0]  phase_reg,    phase_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [2:0]  bit_cnt_reg,  bit_cnt_next;
    logic [7:0]  shift_reg,    shift_next;
    logic [2:0]  tx_total_reg, tx_total_next;
    logic [1:0]  rx_total_reg, rx_total_next;
    logic [7:0]  tries_reg,    tries_next;
    logic [15:0] rx_word_reg,  rx_word_next;
    logic        clk_hi_reg,   clk_hi_next;
    logic [7:0]  tx_bytes [4];

    logic [1:0]  n_data;
    logic [1:0]  n_reply;
    logic [7:0]  opcode;
    logic        tx_bit;
    logic [1:0]  byte_inc;
    logic [15:0] rx_word_new;

    // start beat decode
    always_comb begin
        n_data  = (item.data_count > DATA_LIMIT) ? DATA_LIMIT : item.data_count;
        n_reply = (item.reply_count > REPLY_LIMIT) ? REPLY_LIMIT : item.reply_count;
        opcode  = item.command_byte;
        if (n_reply != 2'd0 && item.force_reply_bit) begin
            opcode = item.command_byte | FORCE_REPLY_MASK;
        end
    end

    assign tx_bit      = shift_reg[7];
    assign byte_inc    = byte_idx_reg + 2'd1;
    assign rx_word_new = {rx_word_reg[7:0], shift_reg};

    // one pin phase per beat
    always_comb begin
        phase_next    = phase_reg;
        byte_idx_next = byte_idx_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        tx_total_next = tx_total_reg;
        rx_total_next = rx_total_reg;
        tries_next    = tries_reg;
        rx_word_next  = rx_word_reg;
        clk_hi_next   = clk_hi_reg;
        res           = '0;

        if (item.cmd == CMD_START) begin
            tx_total_next = 3'd1 + {1'b0, n_data};
            rx_total_next = n_reply;
            tries_next    = ready_tries;
            rx_word_next  = '0;
            byte_idx_next = '0;
            bit_cnt_next  = '0;
            clk_hi_next   = 1'b0;
            shift_next    = opcode;
            phase_next    = PH_TX;
            res.dd_drive  = 1'b1;
        end else begin
            case (phase_reg)
                PH_TX: begin
                    res.dd_drive = 1'b1;
                    res.dd_out   = tx_bit;
                    if (!clk_hi_reg) begin
                        clk_hi_next  = 1'b1;
                        res.dc_level = 1'b1;
                    end else begin
                        clk_hi_next = 1'b0;
                        shift_next  = {shift_reg[6:0], 1'b0};
                        if (bit_cnt_reg != 3'd7) begin
                            bit_cnt_next = bit_cnt_reg + 3'd1;
                        end else begin
                            bit_cnt_next = '0;
                            if ({1'b0, byte_idx_reg} + 3'd1 < tx_total_reg) begin
                                byte_idx_next = byte_inc;
                                shift_next    = tx_bytes[byte_inc];
                            end else begin
                                byte_idx_next = '0;
                                if (rx_total_reg == 2'd0) begin
                                    phase_next   = PH_IDLE;
                                    res.done_res = 1'b1;
                                    res.ok       = 1'b1;
                                end else begin
                                    phase_next = PH_WAIT;
                                end
                            end
                        end
                    end
                end
                PH_WAIT: begin
                    if (tries_reg == 8'd0) begin
                        phase_next   = PH_IDLE;
                        res.dd_drive = 1'b1;
                        res.done_res = 1'b1;
                    end else begin
                        phase_next   = item.dd_in ? PH_DUMMY : PH_RX;
                        bit_cnt_next = '0;
                        clk_hi_next  = 1'b0;
                        shift_next   = '0;
                    end
                end
                PH_DUMMY: begin
                    if (!clk_hi_reg) begin
                        clk_hi_next  = 1'b1;
                        res.dc_level = 1'b1;
                    end else begin
                        clk_hi_next = 1'b0;
                        if (bit_cnt_reg != 3'd7) begin
                            bit_cnt_next = bit_cnt_reg + 3'd1;
                        end else begin
                            bit_cnt_next = '0;
                            tries_next   = tries_reg - 8'd1;
                            phase_next   = PH_WAIT;
                        end
                    end
                end
                PH_RX: begin
                    if (!clk_hi_reg) begin
                        clk_hi_next  = 1'b1;
                        shift_next   = {shift_reg[6:0], item.dd_in};
                        res.dc_level = 1'b1;
                    end else begin
                        clk_hi_next = 1'b0;
                        if (bit_cnt_reg != 3'd7) begin
                            bit_cnt_next = bit_cnt_reg + 3'd1;
                        end else begin
                            bit_cnt_next  = '0;
                            rx_word_next  = rx_word_new;
                            shift_next    = '0;
                            byte_idx_next = byte_inc;
                            if ({1'b0, byte_idx_reg} + 3'd1 >= {1'b0, rx_total_reg}) begin
                                byte_idx_next     = '0;
                                phase_next        = PH_IDLE;
                                res.dd_drive      = 1'b1;
                                res.done_res      = 1'b1;
                                res.ok            = 1'b1;
                                res.response_word = rx_word_new;
                            end
                        end
                    end
                end
                default: begin
                    // idle tick or stray code: drive data low, stay idle
                    phase_next   = PH_IDLE;
                    res.dd_drive = 1'b1;
                end
            endcase
        end
        res.busy_res = (phase_next != PH_IDLE);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            byte_idx_reg <= '0;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            tx_total_reg <= '0;
            rx_total_reg <= '0;
            tries_reg    <= '0;
            rx_word_reg  <= '0;
            clk_hi_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            byte_idx_reg <= byte_idx_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            tx_total_reg <= tx_total_next;
            rx_total_reg <= rx_total_next;
            tries_reg    <= tries_next;
            rx_word_reg  <= rx_word_next;
            clk_hi_reg   <= clk_hi_next;
        end
    end

    // transmit byte store, loaded by every start beat
    always_ff @(posedge aclk) begin
        if (step_en && item.cmd == CMD_START) begin
            tx_bytes[0] <= opcode;
            tx_bytes[1] <= item.data_byte0;
            tx_bytes[2] <= item.data_byte1;
            tx_bytes[3] <= item.data_byte2;
        end
    end

    // a finished transaction leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.done_res |=> phase_reg == PH_IDLE)
        else $error("sequencer not idle after done");

    // ok only ever reported together with done
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.ok |-> res.done_res)
        else $error("ok without done");

    // a released data line never carries a driven level
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !res.dd_drive |-> !res.dd_out)
        else $error("dd_out set while released");

    // reception and dummy clocking keep the data line released until done
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.cmd == CMD_TICK && !res.done_res &&
        (phase_reg == PH_RX || phase_reg == PH_DUMMY) |-> !res.dd_drive)
        else $error("data line driven during target phase");

endmodule

FILE: sv/two_wire_debug_command_master.sv
// Two-wire debug command master (clock DC, bidirectional data DD).
// Input stream: every beat is either a start (tuser low), which loads the
// opcode, up to three data bytes and the number of reply bytes, or a tick
// (tuser high), which advances the pins by one phase and carries the sampled
// DD level. Every input beat gives exactly one output beat holding the DC
// level, DD level and drive enable for that phase plus busy, done, ok and the
// response word. The output beats are fed straight to the pin driver.
// Each beat passes through the input register, then the sequencer step into
// the output register. Throughput: one beat per cycle while the output is not
// stalled; the sequencer state updates in the same cycle as the step.
// Configuration: cfg_data sets the ready poll budget (dummy bytes allowed
// while waiting for the target); always ready. The user must write it only
// while idle; the block does not check this. Reset: the sequencer goes idle,
// the poll budget returns to 16, and both stream registers empty. When
// m_axis_tready is low the output beat holds, one more input beat is taken
// into the input register, then s_axis_tready drops until the output moves.
module two_wire_debug_command_master import twdcm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // command_byte[7:0] data_count[9:8] data_byte0[17:10] data_byte1[25:18]
    // data_byte2[33:26] reply_count[35:34] force_reply_bit[36] dd_in[37]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // dc_level[0] dd_out[1] dd_drive[2] busy_res[3] done_res[4] ok[5]
    // response_word[21:6]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);

    logic       in_vld_reg;
    item_t      in_item_reg;
    logic       out_vld_reg;
    result_t    out_res_reg;
    logic [7:0] ready_tries_reg;
    logic       out_free;
    logic       step_en;
    item_t      s_item;
    result_t    step_res;

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign step_en       = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;
    assign cfg_ready     = 1'b1;

    // unpack the input beat
    always_comb begin
        s_item.cmd             = s_axis_tuser;
        s_item.command_byte    = s_axis_tdata[7:0];
        s_item.data_count      = s_axis_tdata[9:8];
        s_item.data_byte0      = s_axis_tdata[17:10];
        s_item.data_byte1      = s_axis_tdata[25:18];
        s_item.data_byte2      = s_axis_tdata[33:26];
        s_item.reply_count     = s_axis_tdata[35:34];
        s_item.force_reply_bit = s_axis_tdata[36];
        s_item.dd_in           = s_axis_tdata[37];
    end

    // poll budget register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_tries_reg <= READY_TRIES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            ready_tries_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg <= s_item;
        end
    end

    twdcm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .item        (in_item_reg),
        .ready_tries (ready_tries_reg),
        .res         (step_res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg};

endmodule
